// ===== rtl/core/xtpg_pkg.sv =====
// Package for the xorshift test pattern generator.
// Holds the request and word types, the state encoding and fixed constants.
// No dependencies.
package xtpg_pkg;

  localparam int OFFSET_FIELD_W = 24;
  localparam int COUNT_FIELD_W  = 10;
  localparam int SKIP_W         = OFFSET_FIELD_W - 3;

  localparam logic [63:0] SEED_MUL = 64'h9E37_79B9_7F4A_7C15;

  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 7;
  localparam int SHIFT_C = 17;

  typedef struct packed {
    logic [63:0]                 disk_id_high;
    logic [63:0]                 disk_id_low;
    logic [OFFSET_FIELD_W-1:0]   pattern_offset;
    logic [COUNT_FIELD_W-1:0]    byte_count;
  } xtpg_req_t;

  typedef struct packed {
    logic [63:0] word_data;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } xtpg_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_SKIP,
    ST_EMIT
  } xtpg_state_t;

endpackage

// ===== rtl/core/xorshift_test_pattern_generator.sv =====
// Xorshift test pattern generator, top level.
// Instantiates xtpg_seed_mul and xtpg_advance; uses xtpg_pkg.
//
// Usage:
//   in_valid/in_ready/in_word carry one request: disk identifier halves, byte
//   offset and byte count. A request is taken only when the block is idle.
//   out_valid/out_ready/out_word carry the pattern, one 64-bit word per eight
//   bytes, byte 0 in the low byte; the final word has last_word set and its
//   count of valid bytes. A request with a zero count gives no words.
//   Counts above MAX_WORDS*8 are clipped; the offset is masked to OFFSET_BITS.
// Timing:
//   The seed multiply runs on one 32x32 multiplier, then one generator step
//   per cycle: pattern_offset/8 skip steps, then one step per output word,
//   each output step waiting while the output register is held off.
//   in_ready returns once the last word is loaded into the output register.
// Reset and stall:
//   rst_n clears the sequencer and drops out_valid. A held-off word stays in
//   the output register and the generator waits until out_ready.
module xorshift_test_pattern_generator #(
  parameter int MAX_WORDS   = 64,
  parameter int OFFSET_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  xtpg_pkg::xtpg_req_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output xtpg_pkg::xtpg_word_t out_word
);
  import xtpg_pkg::*;

  localparam int OffUsed = (OFFSET_BITS < OFFSET_FIELD_W) ? OFFSET_BITS : OFFSET_FIELD_W;
  localparam logic [OFFSET_FIELD_W-1:0] OffMask =
    OFFSET_FIELD_W'((64'd1 << OffUsed) - 64'd1);
  localparam logic [COUNT_FIELD_W-1:0] MaxBytes = COUNT_FIELD_W'(MAX_WORDS * 8);

  xtpg_state_t              state_r, state_nxt;
  logic [63:0]              gen_r, gen_nxt;
  logic [63:0]              hi_r, hi_nxt;
  logic [SKIP_W-1:0]        skip_r, skip_nxt;
  logic [COUNT_FIELD_W-1:0] bytes_r, bytes_nxt;
  logic                     out_valid_r, out_valid_nxt;
  xtpg_word_t               out_word_r, out_word_nxt;

  logic                      accept;
  logic [OFFSET_FIELD_W-1:0] off_masked;
  logic [COUNT_FIELD_W-1:0]  cnt_clip;
  logic [3:0]                take;
  logic [COUNT_FIELD_W-1:0]  bytes_after;
  logic                      mul_done;
  logic [63:0]               mul_product;
  logic [63:0]               gen_step;
  logic                      out_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign off_masked = in_word.pattern_offset & OffMask;
  assign cnt_clip   = (in_word.byte_count > MaxBytes) ? MaxBytes : in_word.byte_count;
  assign take       = (bytes_r < COUNT_FIELD_W'(8)) ? bytes_r[3:0] : 4'd8;
  assign bytes_after = bytes_r - COUNT_FIELD_W'(take);
  assign out_free   = !out_valid_r || out_ready;

  xtpg_seed_mul u_seed_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept && (in_word.byte_count != '0)),
    .operand (in_word.disk_id_low),
    .done    (mul_done),
    .product (mul_product)
  );

  xtpg_advance u_advance (
    .state_in  (gen_r),
    .state_out (gen_step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gen_r      <= gen_nxt;
    hi_r       <= hi_nxt;
    skip_r     <= skip_nxt;
    bytes_r    <= bytes_nxt;
    out_word_r <= out_word_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    hi_nxt        = hi_r;
    skip_nxt      = skip_r;
    bytes_nxt     = bytes_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_word.byte_count != '0)) begin
          hi_nxt    = in_word.disk_id_high;
          skip_nxt  = off_masked[OFFSET_FIELD_W-1:3];
          bytes_nxt = cnt_clip;
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        if (mul_done) begin
          gen_nxt   = hi_r ^ mul_product;
          state_nxt = (skip_r != '0) ? ST_SKIP : ST_EMIT;
        end
      end
      ST_SKIP: begin
        gen_nxt  = gen_step;
        skip_nxt = skip_r - SKIP_W'(1);
        if (skip_r == SKIP_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          gen_nxt                  = gen_step;
          bytes_nxt                = bytes_after;
          out_word_nxt.word_data   = gen_step;
          out_word_nxt.valid_bytes = take;
          out_word_nxt.last_word   = (bytes_after == '0);
          out_valid_nxt            = 1'b1;
          if (bytes_after == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/core/xtpg_seed_mul.sv =====
// Seed multiplier: low identifier half times the golden-ratio constant, mod 2^64.
// One shared 32x32 multiplier, three partial products in sequence.
// Depends on xtpg_pkg.
module xtpg_seed_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [63:0] product
);
  import xtpg_pkg::*;

  logic [63:0] a_r;
  logic [63:0] acc_r;
  logic [63:0] prod_r;
  logic [1:0]  phase_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] opa;
  logic [31:0] opb;

  always_comb begin
    case (phase_r)
      2'd0: begin
        opa = a_r[31:0];
        opb = SEED_MUL[31:0];
      end
      2'd1: begin
        opa = a_r[31:0];
        opb = SEED_MUL[63:32];
      end
      default: begin
        opa = a_r[63:32];
        opb = SEED_MUL[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 2'd0;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= operand;
    end
    if (busy_r) begin
      prod_r <= 64'(opa) * 64'(opb);
      case (phase_r)
        2'd0:    acc_r <= acc_r;
        2'd1:    acc_r <= prod_r;
        default: acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
      endcase
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== rtl/core/xtpg_advance.sv =====
// One xorshift64 step: shift left 13, right 7, left 17, each folded by XOR.
// Shared by the skip and emit phases of the sequencer.
// Depends on xtpg_pkg.
module xtpg_advance (
  input  logic [63:0] state_in,
  output logic [63:0] state_out
);
  import xtpg_pkg::*;

  logic [63:0] x1;
  logic [63:0] x2;

  assign x1        = state_in ^ (state_in << SHIFT_A);
  assign x2        = x1 ^ (x1 >> SHIFT_B);
  assign state_out = x2 ^ (x2 << SHIFT_C);

endmodule

// ===== rtl/core/xtpg_checker.sv =====
// Port-level checker for the xorshift test pattern generator.
// Bound to xorshift_test_pattern_generator; uses xtpg_pkg.
// Covers output hold, valid byte range, word marking, request sequencing and reset.
module xtpg_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input xtpg_pkg::xtpg_req_t  in_word,
  input logic                 out_valid,
  input logic                 out_ready,
  input xtpg_pkg::xtpg_word_t out_word
);
  import xtpg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_word.byte_count != '0) |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.valid_bytes != 4'd0) && (out_word.valid_bytes <= 4'd8))
    else $error("valid byte count out of range");

  a_partial_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.valid_bytes != 4'd8) |-> out_word.last_word)
    else $error("partial word not marked last");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind xorshift_test_pattern_generator xtpg_checker u_xtpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

// ===== dv/xorshift_test_pattern_generator_tb.sv =====
// Testbench for xorshift_test_pattern_generator: directed and random requests,
// expected pattern words computed in-bench and checked in order at the output.
// Depends on xtpg_pkg and the xorshift_test_pattern_generator RTL.
module xorshift_test_pattern_generator_tb;
  import xtpg_pkg::*;

  localparam int MAX_WORDS      = 64;
  localparam int OFFSET_BITS    = 24;
  localparam int MAX_BYTES      = MAX_WORDS * 8;
  localparam int IDLE_PCT       = 37;
  localparam int WATCHDOG_LIMIT = 10_000_000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int unsigned OFFSET_MAX = (32'd1 << OFFSET_FIELD_W) - 32'd1;

  logic       clk;
  logic       rst_n    = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  xtpg_req_t  in_word  = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  xtpg_word_t out_word;

  xtpg_req_t  requests_pending[$];
  xtpg_word_t pattern_words_expected[$];

  int unsigned requests_taken = 0;
  int unsigned words_taken    = 0;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;

  xorshift_test_pattern_generator #(
    .MAX_WORDS  (MAX_WORDS),
    .OFFSET_BITS(OFFSET_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [63:0] xorshift_next(logic [63:0] x);
    x = x ^ (x << SHIFT_A);
    x = x ^ (x >> SHIFT_B);
    x = x ^ (x << SHIFT_C);
    return x;
  endfunction

  function automatic void predict_pattern(xtpg_req_t req);
    logic [63:0] gen;
    int unsigned bytes_left;
    int unsigned skip;
    int unsigned n;
    xtpg_word_t  w;
    bytes_left = 32'(req.byte_count);
    if (bytes_left == 0) return;
    if (bytes_left > MAX_BYTES) bytes_left = MAX_BYTES;
    gen = req.disk_id_high ^ (req.disk_id_low * SEED_MUL);
    skip = 32'(req.pattern_offset >> 3);
    repeat (skip) gen = xorshift_next(gen);
    while (bytes_left != 0) begin
      n = (bytes_left < 8) ? bytes_left : 8;
      gen = xorshift_next(gen);
      bytes_left -= n;
      w.word_data   = gen;
      w.valid_bytes = n[3:0];
      w.last_word   = (bytes_left == 0);
      pattern_words_expected.push_back(w);
    end
  endfunction

  function automatic void push_request(logic [63:0] hi, logic [63:0] lo,
                                       int unsigned off, int unsigned cnt);
    xtpg_req_t req;
    req.disk_id_high   = hi;
    req.disk_id_low    = lo;
    req.pattern_offset = OFFSET_FIELD_W'(off);
    req.byte_count     = COUNT_FIELD_W'(cnt);
    requests_pending.push_back(req);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_pattern(in_word);
        requests_taken++;
      end
      if (!in_valid || in_ready) begin
        if (requests_pending.size() != 0 &&
            ((requests_taken >= 100 && requests_taken < 180) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_word  <= requests_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // word receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) words_taken++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && words_taken >= 600) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (words_taken >= 1000 && words_taken < 1800) ||
                     ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // word checker
  always @(posedge clk) begin : word_check
    xtpg_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pattern_words_expected.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: data=%h bytes=%0d last=%b",
                   out_word.word_data, out_word.valid_bytes, out_word.last_word);
        mismatches++;
      end else begin
        exp_w = pattern_words_expected.pop_front();
        if (out_word.word_data !== exp_w.word_data ||
            out_word.valid_bytes !== exp_w.valid_bytes ||
            out_word.last_word !== exp_w.last_word) begin
          if (mismatches < 10)
            $display("word mismatch: exp data=%h bytes=%0d last=%b, got data=%h bytes=%0d last=%b",
                     exp_w.word_data, exp_w.valid_bytes, exp_w.last_word,
                     out_word.word_data, out_word.valid_bytes, out_word.last_word);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    xtpg_req_t   req;
    int unsigned pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push_request(64'd0, 64'd0, 0, 8);
    push_request(SEED_MUL * 64'd5, 64'd5, 0, 24);
    push_request('1, '1, 0, 1);
    push_request('1, '1, OFFSET_MAX, MAX_BYTES);
    push_request(64'd1, 64'd0, 0, 64);
    push_request(64'd0, 64'd1, 7, MAX_BYTES);
    push_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 8, 9);
    push_request(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 16);
    push_request({$urandom, $urandom}, {$urandom, $urandom}, 0, 0);
    push_request({$urandom, $urandom}, {$urandom, $urandom}, 4095, 0);
    push_request({$urandom, $urandom}, {$urandom, $urandom}, 0, 1023);
    push_request({$urandom, $urandom}, {$urandom, $urandom}, 0, 513);
    push_request({$urandom, $urandom}, {$urandom, $urandom}, 15, 7);
    push_request({$urandom, $urandom}, {$urandom, $urandom}, 16, 2);
    push_request({$urandom, $urandom}, {$urandom, $urandom}, 1, 511);
    push_request({$urandom, $urandom}, {$urandom, $urandom}, 3, 505);
    push_request({$urandom, $urandom}, {$urandom, $urandom}, 0, 8);

    // hold the next phase until every word is back
    while (requests_pending.size() != 0 || in_valid || pattern_words_expected.size() != 0)
      @(posedge clk);

    repeat (400) begin
      req.disk_id_high = {$urandom, $urandom};
      req.disk_id_low  = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 60)      req.pattern_offset = OFFSET_FIELD_W'($urandom_range(255));
      else if (pick < 90) req.pattern_offset = OFFSET_FIELD_W'($urandom_range(4095));
      else                req.pattern_offset = OFFSET_FIELD_W'($urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < 5)       req.byte_count = '0;
      else if (pick < 10)
        req.byte_count = COUNT_FIELD_W'($urandom_range(1023, MAX_BYTES + 1));
      else if (pick < 20)
        req.byte_count = COUNT_FIELD_W'($urandom_range(MAX_BYTES, MAX_BYTES - 7));
      else if (pick < 35) req.byte_count = COUNT_FIELD_W'($urandom_range(16, 1));
      else if (pick < 80) req.byte_count = COUNT_FIELD_W'($urandom_range(64, 1));
      else                req.byte_count = COUNT_FIELD_W'($urandom_range(MAX_BYTES, 65));
      requests_pending.push_back(req);
    end

    while (requests_pending.size() != 0 || in_valid || pattern_words_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pattern_words_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
